[design/stt_pkg.sv]
// Shared types and constants for the software timer table.
`default_nettype none

package stt_pkg;

	// Time and field widths fixed by the item format.
	localparam int TIME_W     = 31;
	localparam int DELAY_W    = 32;
	localparam int TAG_OUT_W  = 16;
	localparam int SLOT_OUT_W = 4;
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 56;

	// Request codes.
	typedef enum logic [1:0] {
		ACT_CREATE = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_RESET  = 2'd2,
		ACT_STEP   = 2'd3
	} action_t;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_CREATED  = 3'd0,
		KIND_DELETED  = 3'd1,
		KIND_RESET    = 3'd2,
		KIND_FIRED    = 3'd3,
		KIND_FINISHED = 3'd4
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_INVALID  = 2'd1,
		STS_OVERFLOW = 2'd2,
		STS_NO_SLOT  = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_FIND,
		FSM_CALC,
		FSM_DEL,
		FSM_RD,
		FSM_EVAL,
		FSM_FIN
	} state_t;

	// Operations of the shared time unit.
	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// Flags and value produced by the shared time unit.
	typedef struct packed {
		logic [DELAY_W-1:0] value;
		logic               overflow;
		logic               not_after;
		logic               below_bound;
	} alu_res_t;

endpackage

`default_nettype wire

[design/stt_alu.sv]
// Shared add/subtract and compare unit for expiry arithmetic.
`default_nettype none

module stt_alu
	import stt_pkg::*;
(
	input  alu_op_t           op,
	input  logic [TIME_W-1:0] a,
	input  logic [TIME_W-1:0] b,
	input  logic [TIME_W-1:0] bound,
	output alu_res_t          res
);

	logic              sub;
	logic [DELAY_W-1:0] operand;
	logic [DELAY_W-1:0] value;

	// One adder serves both a + b and a - b.
	assign sub     = (op == ALU_SUB);
	assign operand = sub ? ~{1'b0, b} : {1'b0, b};
	assign value   = {1'b0, a} + operand + {{(DELAY_W-1){1'b0}}, sub};

	// The top bit flags a sum past 31 bits, or a negative difference.
	always_comb begin
		res.value       = value;
		res.overflow    = value[DELAY_W-1];
		res.not_after   = value[DELAY_W-1] | (value == '0);
		res.below_bound = (value[TIME_W-1:0] < bound);
	end

endmodule

`default_nettype wire

[design/stt_mem.sv]
// Expiry time and tag storage, one write and one registered read per cycle.
`default_nettype none

module stt_mem
	import stt_pkg::*;
#(
	parameter int SLOT_COUNT = 16,
	parameter int TAG_BITS   = 16,
	parameter int SLOT_W     = 4
) (
	input  logic                clk,
	input  logic                exp_we,
	input  logic                tag_we,
	input  logic [SLOT_W-1:0]   wr_addr,
	input  logic [TIME_W-1:0]   wr_exp,
	input  logic [TAG_BITS-1:0] wr_tag,
	input  logic [SLOT_W-1:0]   rd_addr,
	output logic [TIME_W-1:0]   rd_exp,
	output logic [TAG_BITS-1:0] rd_tag
);

	logic [TIME_W-1:0]   exp_mem [SLOT_COUNT];
	logic [TAG_BITS-1:0] tag_mem [SLOT_COUNT];
	logic [TIME_W-1:0]   rd_exp_q;
	logic [TAG_BITS-1:0] rd_tag_q;

	// Writes; expiry and tag have separate enables so a reload keeps the tag.
	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[wr_addr] <= wr_exp;
		end
		if (tag_we) begin
			tag_mem[wr_addr] <= wr_tag;
		end
	end

	// Registered read.
	always_ff @(posedge clk) begin
		rd_exp_q <= exp_mem[rd_addr];
		rd_tag_q <= tag_mem[rd_addr];
	end

	assign rd_exp = rd_exp_q;
	assign rd_tag = rd_tag_q;

endmodule

`default_nettype wire

[design/software_timer_table_top.sv]
// Top level of the software timer table: sequencer, valid bits and output register.
//
// Requests arrive on the s_ stream (tuser carries the action) and results
// leave on the m_ stream (tuser carries the result kind, tlast marks the
// final result of a request). Create, delete and reset give one result;
// step gives one fired result per expired timer, in slot order, and then
// one finished result with the smallest remaining delay, capped by the
// bound given with the request.
// A request is handled one at a time; s_tready is high only while idle.
// Create searches for the lowest free slot, looking at one slot per cycle;
// step reads the expiry memory and compares it with the current time
// through one shared add/subtract unit, one slot per cycle while the
// output is free or the slot does not fire.
// One output register holds a result; the next request is taken while a
// result still waits. When the receiver stalls the sequencer waits on the
// slot it is handling and resumes without losing or repeating a result.
// Reset clears all timers to inactive and empties the output register;
// no clearing pass is needed.
`default_nettype none

module software_timer_table_top
	import stt_pkg::*;
#(
	parameter int SLOT_COUNT = 16,
	parameter int TAG_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// slot[3:0], delay[35:4], user_tag[51:36], now[82:52], timeout_in[113:83], zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// action[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[1:0], slot_out[5:2], tag_out[21:6], timeout_out[52:22], zero pad
	output logic [OUT_DATA_W-1:0] m_tdata,
	// result_kind[2:0]
	output logic [2:0]            m_tuser,
	output logic                  m_tlast
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

	// Sequencer and table state.
	state_t                  state_q, state_d;
	logic [SLOT_W-1:0]       idx_q;
	logic [SLOT_COUNT-1:0]   active_q;

	// Latched request.
	action_t                 action_q;
	logic [SLOT_OUT_W-1:0]   slot_q;
	logic [DELAY_W-1:0]      delay_q;
	logic [TAG_OUT_W-1:0]    tag_q;
	logic [TIME_W-1:0]       now_q;
	logic [TIME_W-1:0]       tmo_q;

	// Output register.
	logic                    m_tvalid_q;
	kind_t                   out_kind_q;
	status_t                 out_status_q;
	logic [SLOT_OUT_W-1:0]   out_slot_q;
	logic [TAG_OUT_W-1:0]    out_tag_q;
	logic [TIME_W-1:0]       out_tmo_q;
	logic                    out_last_q;

	// Control produced by the sequencer.
	logic                    accept;
	logic                    out_free;
	logic                    delay_bad;
	logic                    in_range;
	logic [SLOT_W-1:0]       slot_idx;
	logic                    emit;
	kind_t                   e_kind;
	status_t                 e_status;
	logic [SLOT_OUT_W-1:0]   e_slot;
	logic [TAG_OUT_W-1:0]    e_tag;
	logic [TIME_W-1:0]       e_tmo;
	logic                    e_last;
	logic                    idx_inc;
	logic                    act_set;
	logic                    act_clr;
	logic [SLOT_W-1:0]       act_addr;
	logic                    exp_we;
	logic                    tag_we;
	logic [SLOT_W-1:0]       wr_addr;
	logic [SLOT_W-1:0]       rd_addr;
	logic                    tmo_ld;
	logic                    fire;
	alu_op_t                 alu_op;
	logic [TIME_W-1:0]       alu_a;
	logic [TIME_W-1:0]       alu_b;
	alu_res_t                alu_res;
	logic [TIME_W-1:0]       rd_exp;
	logic [TAG_BITS-1:0]     rd_tag;

	assign s_tready  = (state_q == FSM_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign out_free  = ~m_tvalid_q | m_tready;
	assign delay_bad = (delay_q == '0) | delay_q[DELAY_W-1];
	assign in_range  = ({{(DELAY_W-SLOT_OUT_W){1'b0}}, slot_q} < DELAY_W'(SLOT_COUNT));
	assign slot_idx  = SLOT_W'(slot_q);

	// Shared unit: now + delay for create and reset, expiry - now for step.
	assign alu_a = (alu_op == ALU_ADD) ? now_q : rd_exp;
	assign alu_b = (alu_op == ALU_ADD) ? delay_q[TIME_W-1:0] : now_q;

	stt_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.bound (tmo_q),
		.res   (alu_res)
	);

	stt_mem #(
		.SLOT_COUNT (SLOT_COUNT),
		.TAG_BITS   (TAG_BITS),
		.SLOT_W     (SLOT_W)
	) u_mem (
		.clk     (clk),
		.exp_we  (exp_we),
		.tag_we  (tag_we),
		.wr_addr (wr_addr),
		.wr_exp  (alu_res.value[TIME_W-1:0]),
		.wr_tag  (TAG_BITS'(tag_q)),
		.rd_addr (rd_addr),
		.rd_exp  (rd_exp),
		.rd_tag  (rd_tag)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and sequencer outputs.
	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		e_kind   = KIND_CREATED;
		e_status = STS_OK;
		e_slot   = '0;
		e_tag    = '0;
		e_tmo    = '0;
		e_last   = 1'b1;
		idx_inc  = 1'b0;
		act_set  = 1'b0;
		act_clr  = 1'b0;
		act_addr = idx_q;
		exp_we   = 1'b0;
		tag_we   = 1'b0;
		wr_addr  = idx_q;
		rd_addr  = idx_q;
		tmo_ld   = 1'b0;
		fire     = 1'b0;
		alu_op   = ALU_ADD;
		case (state_q)
			FSM_IDLE: begin
				if (s_tvalid) begin
					case (action_t'(s_tuser))
						ACT_CREATE: state_d = FSM_FIND;
						ACT_DELETE: state_d = FSM_DEL;
						ACT_RESET:  state_d = FSM_CALC;
						ACT_STEP:   state_d = FSM_RD;
						default:    state_d = FSM_IDLE;
					endcase
				end
			end
			// Create: reject a bad delay, else look for the lowest free slot.
			FSM_FIND: begin
				if (delay_bad) begin
					if (out_free) begin
						emit     = 1'b1;
						e_status = STS_INVALID;
						state_d  = FSM_IDLE;
					end
				end else if (!active_q[idx_q]) begin
					state_d = FSM_CALC;
				end else if (idx_q == LAST_IDX) begin
					if (out_free) begin
						emit     = 1'b1;
						e_status = STS_NO_SLOT;
						state_d  = FSM_IDLE;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			// Create into the found slot, or reload an existing slot.
			FSM_CALC: begin
				alu_op = ALU_ADD;
				if (out_free) begin
					emit    = 1'b1;
					state_d = FSM_IDLE;
					if (action_q == ACT_CREATE) begin
						e_kind = KIND_CREATED;
					end else begin
						e_kind = KIND_RESET;
						e_slot = slot_q;
					end
					if (delay_bad) begin
						e_status = STS_INVALID;
					end else if (alu_res.overflow) begin
						e_status = STS_OVERFLOW;
					end else if (action_q == ACT_CREATE) begin
						e_slot  = SLOT_OUT_W'(idx_q);
						exp_we  = 1'b1;
						tag_we  = 1'b1;
						act_set = 1'b1;
					end else if (in_range) begin
						exp_we  = 1'b1;
						wr_addr = slot_idx;
					end
				end
			end
			// Delete frees the slot when it exists.
			FSM_DEL: begin
				if (out_free) begin
					emit     = 1'b1;
					e_kind   = KIND_DELETED;
					e_slot   = slot_q;
					act_clr  = in_range;
					act_addr = slot_idx;
					state_d  = FSM_IDLE;
				end
			end
			// First read of the step scan.
			FSM_RD: begin
				state_d = FSM_EVAL;
			end
			// One slot per cycle; hold on a fired slot until the output frees.
			FSM_EVAL: begin
				alu_op = ALU_SUB;
				fire   = active_q[idx_q] & alu_res.not_after;
				if (!fire || out_free) begin
					if (fire) begin
						emit    = 1'b1;
						e_kind  = KIND_FIRED;
						e_slot  = SLOT_OUT_W'(idx_q);
						e_tag   = TAG_OUT_W'(rd_tag);
						e_last  = 1'b0;
						act_clr = 1'b1;
					end else if (active_q[idx_q] && alu_res.below_bound) begin
						tmo_ld = 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						state_d = FSM_FIN;
					end else begin
						idx_inc = 1'b1;
						rd_addr = idx_q + 1'b1;
					end
				end
			end
			FSM_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_FINISHED;
					e_tmo   = tmo_q;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Slot counter shared by the free-slot search and the step scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Active bits of the timer slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else begin
			if (act_set) begin
				active_q[act_addr] <= 1'b1;
			end
			if (act_clr) begin
				active_q[act_addr] <= 1'b0;
			end
		end
	end

	// Request latch and running timeout.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action_t'(s_tuser);
			slot_q   <= s_tdata[3:0];
			delay_q  <= s_tdata[35:4];
			tag_q    <= s_tdata[51:36];
			now_q    <= s_tdata[82:52];
			tmo_q    <= s_tdata[113:83];
		end else if (tmo_ld) begin
			tmo_q <= alu_res.value[TIME_W-1:0];
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q   <= e_kind;
			out_status_q <= e_status;
			out_slot_q   <= e_slot;
			out_tag_q    <= e_tag;
			out_tmo_q    <= e_tmo;
			out_last_q   <= e_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'd0, out_tmo_q, out_tag_q, out_slot_q, out_status_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

[design/stt_checker.sv]
// Port-level checks for the software timer table, bound to the top level.
`default_nettype none

module stt_checker
	import stt_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic [2:0]            m_tuser,
	input wire logic                  m_tlast
);

	// A stalled result holds its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// The block is not ready again in the cycle after it takes a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// Fired results never close a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_FIRED) |-> !m_tlast)
		else $error("fired result marked last");

	// Every other result closes its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_FIRED) |-> m_tlast)
		else $error("single result not marked last");

	// Only fired results carry a tag.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_FIRED) |-> (m_tdata[21:6] == '0))
		else $error("tag on a result that is not fired");

endmodule

bind software_timer_table_top stt_checker u_stt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

[tb/sv/software_timer_table_checker.sv]
// Checker for the software timer table: tracks the timer table and compares every result.
module software_timer_table_checker
	import stt_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [2:0]            m_tuser,
	input  logic                  m_tlast,
	output int                    failures,
	output int                    results_owed
);

	typedef struct {
		kind_t             kind;
		status_t           status;
		logic [3:0]        slot;
		logic [15:0]       tag;
		logic [TIME_W-1:0] timeout;
		logic              last;
	} timer_result_t;

	// Results the block still owes, oldest first.
	timer_result_t owed_q[$];

	// Shadow copy of the timer table.
	logic [TIME_W-1:0] due_time [SLOT_COUNT];
	logic [15:0]       live_tag [SLOT_COUNT];
	bit                live     [SLOT_COUNT];

	function automatic void owe(kind_t kind, status_t status, logic [3:0] slot,
			logic [15:0] tag, logic [TIME_W-1:0] timeout, logic last);
		timer_result_t r;
		r.kind    = kind;
		r.status  = status;
		r.slot    = slot;
		r.tag     = tag;
		r.timeout = timeout;
		r.last    = last;
		owed_q.push_back(r);
	endfunction

	// Validates a delay against the current time and computes the expiry.
	function automatic status_t delay_status(input logic [DELAY_W-1:0] delay,
			input logic [TIME_W-1:0] now, output logic [TIME_W-1:0] expiry);
		logic [32:0] sum;
		sum    = {2'b00, now} + {1'b0, delay};
		expiry = sum[TIME_W-1:0];
		if (delay == '0 || delay[DELAY_W-1]) return STS_INVALID;
		if (sum > 33'h0_7FFF_FFFF) return STS_OVERFLOW;
		return STS_OK;
	endfunction

	// Updates the table for one request and queues the results it causes.
	function automatic void apply_timer_request(action_t act, logic [3:0] slot,
			logic [DELAY_W-1:0] delay, logic [15:0] tag, logic [TIME_W-1:0] now,
			logic [TIME_W-1:0] bound);
		status_t           status;
		logic [TIME_W-1:0] expiry;
		logic [TIME_W-1:0] shortest;
		int                free_idx;
		free_idx = -1;
		shortest = bound;
		case (act)
			ACT_CREATE: begin
				// Delay first, then a free slot, then overflow of the expiry.
				status = (delay == '0 || delay[DELAY_W-1]) ? STS_INVALID : STS_OK;
				if (status == STS_OK) begin
					for (int i = 0; i < SLOT_COUNT; i++)
						if (!live[i] && free_idx < 0) free_idx = i;
					if (free_idx < 0)
						status = STS_NO_SLOT;
					else
						status = delay_status(delay, now, expiry);
				end
				if (status == STS_OK) begin
					due_time[free_idx] = expiry;
					live_tag[free_idx] = tag;
					live[free_idx]     = 1'b1;
					owe(KIND_CREATED, STS_OK, 4'(free_idx), '0, '0, 1'b1);
				end else begin
					owe(KIND_CREATED, status, '0, '0, '0, 1'b1);
				end
			end
			ACT_DELETE: begin
				if (slot < SLOT_COUNT) live[slot] = 1'b0;
				owe(KIND_DELETED, STS_OK, slot, '0, '0, 1'b1);
			end
			ACT_RESET: begin
				// An inactive slot still takes the new expiry but stays inactive.
				status = delay_status(delay, now, expiry);
				if (status == STS_OK && slot < SLOT_COUNT) due_time[slot] = expiry;
				owe(KIND_RESET, status, slot, '0, '0, 1'b1);
			end
			default: begin
				// Fire expired timers in slot order, then report the shortest wait.
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (live[i]) begin
						if (due_time[i] <= now) begin
							owe(KIND_FIRED, STS_OK, 4'(i), live_tag[i], '0, 1'b0);
							live[i] = 1'b0;
						end else if (due_time[i] - now < shortest) begin
							shortest = due_time[i] - now;
						end
					end
				end
				owe(KIND_FINISHED, STS_OK, '0, '0, shortest, 1'b1);
			end
		endcase
	endfunction

	// Both channels are sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		timer_result_t got;
		timer_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) live[i] = 1'b0;
			owed_q.delete();
			failures = 0;
		end else begin
			if (s_tvalid && s_tready)
				apply_timer_request(action_t'(s_tuser), s_tdata[3:0], s_tdata[35:4],
					s_tdata[51:36], s_tdata[82:52], s_tdata[113:83]);
			if (m_tvalid && m_tready) begin
				got.kind    = kind_t'(m_tuser);
				got.status  = status_t'(m_tdata[1:0]);
				got.slot    = m_tdata[5:2];
				got.tag     = m_tdata[21:6];
				got.timeout = m_tdata[52:22];
				got.last    = m_tlast;
				if (owed_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected result: kind %0d status %0d slot %0d",
							got.kind, got.status, got.slot);
				end else begin
					want = owed_q.pop_front();
					if (got.kind !== want.kind || got.status !== want.status ||
							got.slot !== want.slot || got.tag !== want.tag ||
							got.timeout !== want.timeout || got.last !== want.last) begin
						failures++;
						if (failures <= 10)
							$display({"result mismatch: kind/status/slot/tag/timeout/last ",
								"expected %0d/%0d/%0d/%h/%0d/%0d got %0d/%0d/%0d/%h/%0d/%0d"},
								want.kind, want.status, want.slot, want.tag, want.timeout,
								want.last, got.kind, got.status, got.slot, got.tag,
								got.timeout, got.last);
					end
				end
			end
		end
		results_owed = owed_q.size();
	end

endmodule

[tb/sv/software_timer_table_top_tb.sv]
// Testbench top for the software timer table: clock, reset, requests and verdict.
module software_timer_table_top_tb;
	import stt_pkg::*;

	localparam int SLOT_COUNT    = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 2 * SLOT_COUNT + 8;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic [1:0]            s_tuser  = ACT_CREATE;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  m_tlast;

	int                failures;
	int                results_owed;
	int                cycles    = 0;
	int                send_idle = 19;
	int                recv_idle = 65;
	logic [TIME_W-1:0] clock_now = '0;

	software_timer_table_top #(
		.SLOT_COUNT(SLOT_COUNT),
		.TAG_BITS  (16)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	software_timer_table_checker #(
		.SLOT_COUNT(SLOT_COUNT)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.failures    (failures),
		.results_owed(results_owed)
	);

	always #6 clk = ~clk;

	// Receiver stalls at random, one decision per cycle.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("software_timer_table_top_tb: done, errors");
			$finish;
		end
	end

	// Presents one request after a random gap and holds it until accepted.
	task automatic send_request(action_t act, logic [3:0] slot, logic [DELAY_W-1:0] delay,
			logic [15:0] tag, logic [TIME_W-1:0] now, logic [TIME_W-1:0] bound);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {6'b0, bound, now, tag, delay, slot};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Holds off new requests until every owed result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
	endtask

	// Mostly short valid delays, with zero, negative and huge ones mixed in.
	function automatic logic [DELAY_W-1:0] pick_delay();
		int r;
		r = $urandom_range(99);
		if (r < 75) return DELAY_W'($urandom_range(80, 1));
		if (r < 83) return '0;
		if (r < 91) return {1'b1, 31'($urandom)};
		return $urandom;
	endfunction

	// Random requests that follow a mostly advancing clock.
	task automatic random_requests(int count);
		int                r;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] bound;
		for (int n = 0; n < count; n++) begin
			r     = $urandom_range(99);
			now   = ($urandom_range(9) == 0) ? TIME_W'($urandom) : clock_now;
			bound = ($urandom_range(4) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(100));
			if (r < 35) begin
				send_request(ACT_CREATE, 4'($urandom), pick_delay(), 16'($urandom), now, bound);
			end else if (r < 50) begin
				send_request(ACT_DELETE, 4'($urandom), $urandom, 16'($urandom), now, bound);
			end else if (r < 65) begin
				send_request(ACT_RESET, 4'($urandom), pick_delay(), 16'($urandom), now, bound);
			end else begin
				// Time moves forward before a scan, now and then jumping to a random point.
				if ($urandom_range(19) == 0)
					clock_now = TIME_W'($urandom_range(32'h7FFF_FFFF, 0));
				else if (clock_now < 31'h7FFF_FF00)
					clock_now = clock_now + TIME_W'($urandom_range(60));
				send_request(ACT_STEP, 4'($urandom), $urandom, 16'($urandom), clock_now, bound);
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Scan of an empty table reports the bound itself.
		send_request(ACT_STEP, 4'd0, '0, '0, '0, 31'h7FFF_FFFF);
		// Zero and negative delays are refused, then an expiry past the time range.
		send_request(ACT_CREATE, 4'd0, 32'd0, 16'hFFFF, '0, '0);
		send_request(ACT_CREATE, 4'd0, 32'h8000_0000, 16'h0000, '0, '0);
		send_request(ACT_CREATE, 4'd0, 32'd1, 16'h1234, 31'h7FFF_FFFF, '0);
		// Largest expiry that still fits, then fill the rest of the table.
		send_request(ACT_CREATE, 4'd15, 32'h7FFF_FFFF, 16'hFFFF, '0, '0);
		for (int i = 1; i < SLOT_COUNT; i++)
			send_request(ACT_CREATE, 4'd0, DELAY_W'(i * 10), 16'(i), '0, '0);
		// Full table wins over an overflowing expiry.
		send_request(ACT_CREATE, 4'd0, 32'd5, 16'hAAAA, '0, '0);
		send_request(ACT_CREATE, 4'd0, 32'd100, 16'h5555, 31'h7FFF_FFFB, '0);
		// Delete of a live slot, then of the same slot once freed.
		send_request(ACT_DELETE, 4'd3, '0, '0, '0, '0);
		send_request(ACT_DELETE, 4'd3, '0, '0, '0, '0);
		// Reset of a live slot, of a free slot, with a negative delay and with an overflowing expiry.
		send_request(ACT_RESET, 4'd5, 32'd1000, '0, '0, '0);
		send_request(ACT_RESET, 4'd3, 32'd5, '0, '0, '0);
		send_request(ACT_RESET, 4'd5, 32'hFFFF_FFFF, '0, '0, '0);
		send_request(ACT_RESET, 4'd5, 32'h7FFF_FFFF, '0, 31'h7FFF_FFF0, '0);
		// Partial scan, a scan at the end of time that fires everything, then one of the empty table.
		send_request(ACT_STEP, 4'd0, '0, '0, 31'd60, 31'h7FFF_FFFF);
		send_request(ACT_STEP, 4'd0, '0, '0, 31'h7FFF_FFFF, 31'd1000);
		send_request(ACT_STEP, 4'd0, '0, '0, 31'h7FFF_FFFF, '0);
		wait_drained();

		clock_now = TIME_W'($urandom_range(1000));
		random_requests(23);
		wait_drained();
		send_idle = 65;
		recv_idle = 19;
		random_requests(23);
		wait_drained();
		send_idle = 0;
		recv_idle = 0;
		random_requests(23);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (failures == 0 && results_owed == 0)
			$display("software_timer_table_top_tb: done, clean");
		else
			$display("software_timer_table_top_tb: done, errors");
		$finish;
	end

endmodule

[software_timer_table_top.f]
design/stt_pkg.sv
design/stt_alu.sv
design/stt_mem.sv
design/software_timer_table_top.sv
design/stt_checker.sv
tb/sv/software_timer_table_checker.sv
tb/sv/software_timer_table_top_tb.sv
